>>> hw/rtl/pmt_pkg.sv
// ----------------------------------------------------------------------------
// pmt_pkg: shared types, constants and helpers
// Item layout carried down the pipeline, register indexes, mode codes and
// the square root digit step.
// ----------------------------------------------------------------------------
package pmt_pkg;

    // Register indexes on the configuration port
    localparam logic REG_MODE      = 1'b0;
    localparam logic REG_THRESHOLD = 1'b1;

    typedef enum logic [1:0] {
        MODE_ABS    = 2'd0,
        MODE_LOG10  = 2'd1,
        MODE_SQRT   = 2'd2,
        MODE_SQUARE = 2'd3
    } pmt_mode_t;

    // Iteration stages: one log2 squaring round each
    localparam int LOG_ROUNDS  = 32;
    // Iteration stages that also do two square root digit steps each
    localparam int SQRT_STAGES = 20;

    // round(log10(2) * 2^32)
    localparam logic [30:0] LOG10_2_Q32 = 31'd1292913986;

    localparam logic [63:0] LOG_ZERO_VALUE = 64'h8000_0000_0000_0000;

    // Item state between iteration stages
    typedef struct packed {
        pmt_mode_t   mode;
        logic [31:0] mag;    // |pixel|
        logic [31:0] a;      // clamped magnitude
        logic        a_zero;
        logic [4:0]  n;      // top set bit of a
        logic [31:0] m;      // mantissa, Q1.31
        logic [31:0] frac;   // log2 fraction bits
        logic [41:0] rem;    // square root remainder
        logic [39:0] root;   // square root partial result
    } pmt_item_t;

    // Item state after the multiply stage
    typedef struct packed {
        pmt_mode_t   mode;
        logic [31:0] mag;
        logic        a_zero;
        logic        neg;
        logic [39:0] root;
        logic [35:0] prod_hi; // integer part of log2 times constant
        logic [63:0] prod;    // fraction times constant, or the square
    } pmt_scaled_t;

    typedef struct packed {
        logic [41:0] rem;
        logic [39:0] root;
    } pmt_sqrt_t;

    // One digit of floor(sqrt(a * 2^48)); digit index i counts down from 39
    function automatic pmt_sqrt_t sqrt_step(input logic [41:0] rem,
                                            input logic [39:0] root,
                                            input logic [31:0] a,
                                            input logic [5:0]  i);
        pmt_sqrt_t   res;
        logic [1:0]  pair;
        logic [6:0]  pos;
        logic [31:0] shifted;
        logic [43:0] rem_w;
        logic [43:0] trial;
        pos     = {i, 1'b0};
        shifted = a >> (pos - 7'd48);
        pair    = (pos >= 7'd48) ? shifted[1:0] : 2'b00;
        rem_w   = {rem, pair};
        trial   = {2'b00, root, 2'b01};
        if (rem_w >= trial) begin
            rem_w    = rem_w - trial;
            res.root = {root[38:0], 1'b1};
        end
        else begin
            res.root = {root[38:0], 1'b0};
        end
        res.rem = rem_w[41:0];
        return res;
    endfunction

endpackage

>>> hw/rtl/pmt_front.sv
// ----------------------------------------------------------------------------
// pmt_front: input stage
// Magnitude, threshold clamp and normalization of the clamped value.
// ----------------------------------------------------------------------------
module pmt_front
    import pmt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [31:0] pixel,
    input  pmt_mode_t   mode,
    input  logic [30:0] threshold,
    output logic        out_valid,
    output pmt_item_t   out_item
);

    logic      valid_reg;
    pmt_item_t item_reg;
    pmt_item_t item_next;

    // Magnitude, clamp and leading-one normalize
    always_comb
    begin
        logic [31:0] mag;
        logic [31:0] a;
        logic [4:0]  n;
        mag = pixel[31] ? (32'd0 - pixel) : pixel;
        a   = (mag < {1'b0, threshold}) ? {1'b0, threshold} : mag;
        n   = 5'd0;
        for (int k = 0; k < 32; k++) begin
            if (a[k]) begin
                n = 5'(k);
            end
        end
        item_next.mode   = mode;
        item_next.mag    = mag;
        item_next.a      = a;
        item_next.a_zero = (a == 32'd0);
        item_next.n      = n;
        item_next.m      = a << (5'd31 - n);
        item_next.frac   = 32'd0;
        item_next.rem    = 42'd0;
        item_next.root   = 40'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

>>> hw/rtl/pmt_iter.sv
// ----------------------------------------------------------------------------
// pmt_iter: one iteration stage
// One log2 squaring round and, in the first stages, two square root digits.
// ----------------------------------------------------------------------------
module pmt_iter
    import pmt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic [5:0]  idx,       // stage number, 1 up to LOG_ROUNDS
    input  logic        in_valid,
    input  pmt_item_t   in_item,
    output logic        out_valid,
    output pmt_item_t   out_item
);

    logic      valid_reg;
    pmt_item_t item_reg;
    pmt_item_t item_next;

    always_comb
    begin
        logic [63:0] sq;
        logic [32:0] sh;
        logic [5:0]  dig;
        pmt_sqrt_t   s1;
        pmt_sqrt_t   s2;
        item_next = in_item;
        // log2 fraction bit: square the mantissa, renormalize on overflow
        sq = {32'd0, in_item.m} * {32'd0, in_item.m};
        sh = sq[63:31];
        if (sh[32]) begin
            item_next.m = sh[32:1];
            item_next.frac[5'(6'd32 - idx)] = 1'b1;
        end
        else begin
            item_next.m = sh[31:0];
        end
        // Square root digits 41-2*idx and 40-2*idx
        dig = 6'd41 - {idx[4:0], 1'b0};
        s1  = sqrt_step(in_item.rem, in_item.root, in_item.a, dig);
        s2  = sqrt_step(s1.rem, s1.root, in_item.a, dig - 6'd1);
        if (idx <= 6'(SQRT_STAGES)) begin
            item_next.rem  = s2.rem;
            item_next.root = s2.root;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

>>> hw/rtl/pmt_scale.sv
// ----------------------------------------------------------------------------
// pmt_scale: multiply stage
// Forms |log2| and scales it by log10(2); the same multiplier squares the
// magnitude in square mode.
// ----------------------------------------------------------------------------
module pmt_scale
    import pmt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  pmt_item_t   in_item,
    output logic        out_valid,
    output pmt_scaled_t out_item
);

    logic        valid_reg;
    pmt_scaled_t item_reg;
    pmt_scaled_t item_next;

    always_comb
    begin
        logic        neg;
        logic [4:0]  hi;
        logic [31:0] lo;
        logic [31:0] op_a;
        logic [31:0] op_b;
        neg = (in_item.n < 5'd16);
        // |log2(a)| as integer part hi and fraction lo
        if (!neg) begin
            hi = in_item.n - 5'd16;
            lo = in_item.frac;
        end
        else if (in_item.frac == 32'd0) begin
            hi = 5'd16 - in_item.n;
            lo = 32'd0;
        end
        else begin
            hi = 5'd15 - in_item.n;
            lo = 32'd0 - in_item.frac;
        end
        op_a = (in_item.mode == MODE_SQUARE) ? in_item.mag : lo;
        op_b = (in_item.mode == MODE_SQUARE) ? in_item.mag : {1'b0, LOG10_2_Q32};
        item_next.mode    = in_item.mode;
        item_next.mag     = in_item.mag;
        item_next.a_zero  = in_item.a_zero;
        item_next.neg     = neg;
        item_next.root    = in_item.root;
        item_next.prod_hi = 36'(hi) * 36'(LOG10_2_Q32);
        item_next.prod    = 64'(op_a) * 64'(op_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

>>> hw/rtl/pmt_finish.sv
// ----------------------------------------------------------------------------
// pmt_finish: rounding and result select
// Rounds the scaled log to 2^-16, applies the sign and picks the result
// for the mode; holds the output register.
// ----------------------------------------------------------------------------
module pmt_finish
    import pmt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  pmt_scaled_t in_item,
    output logic        out_valid,
    output logic [63:0] value,
    output logic        domain_error
);

    logic        valid_reg;
    logic [63:0] value_reg;
    logic [63:0] value_next;
    logic        err_reg;
    logic        err_next;

    always_comb
    begin
        logic [63:0] t;
        logic [63:0] r;
        logic [63:0] v;
        t = {12'd0, in_item.prod_hi, 16'd0} + {16'd0, in_item.prod[63:16]};
        r = (t + 64'h8000_0000) >> 32;
        v = {r[47:0], 16'd0};
        err_next = 1'b0;
        unique case (in_item.mode)
            MODE_ABS:    value_next = {16'd0, in_item.mag, 16'd0};
            MODE_SQUARE: value_next = in_item.prod;
            MODE_SQRT:   value_next = {24'd0, in_item.root};
            MODE_LOG10:
            begin
                if (in_item.a_zero) begin
                    value_next = LOG_ZERO_VALUE;
                    err_next   = 1'b1;
                end
                else begin
                    value_next = in_item.neg ? (64'd0 - v) : v;
                end
            end
            default:     value_next = 64'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            value_reg <= value_next;
            err_reg   <= err_next;
        end
    end

    assign out_valid    = valid_reg;
    assign value        = value_reg;
    assign domain_error = err_reg;

endmodule

>>> hw/rtl/pixel_magnitude_transform_core.sv
// ----------------------------------------------------------------------------
// pixel_magnitude_transform_core: per-pixel magnitude transform
// Abs, log10, sqrt or square of a Q16.16 pixel as a Q32.32 result.
// ----------------------------------------------------------------------------
//  channel   dir   signals                         payload
//  s_axis    in    s_tvalid s_tready s_tdata       pixel (32b)
//  m_axis    out   m_tvalid m_tready m_tdata       value (64b)
//                            m_tuser               domain_error
//  apb       in    psel penable pwrite paddr ...   mode @0x0, threshold @0x4
//
// One pixel per cycle unless the pipe holds. Stages: input stage, 32 iteration
// stages (one log2 squaring multiply each), a multiply stage and the output
// register. Every stage advances together when the output register is empty
// or is being read; otherwise the whole pipe holds. Reset clears all valid
// bits and the configuration registers to zero; data registers are not reset.
// ----------------------------------------------------------------------------
module pixel_magnitude_transform_core
    import pmt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] pixel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] value
    output logic        m_tuser,   // [0] domain_error
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    pmt_mode_t   mode_reg;
    logic [30:0] threshold_reg;
    logic        en;
    logic        cfg_wr;

    logic        iv [0:LOG_ROUNDS];
    pmt_item_t   it [0:LOG_ROUNDS];
    logic        sc_valid;
    pmt_scaled_t sc_item;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg      <= MODE_ABS;
            threshold_reg <= 31'd0;
        end
        else if (cfg_wr) begin
            unique case (paddr[2])
                REG_MODE:      mode_reg      <= pmt_mode_t'(pwdata[1:0]);
                REG_THRESHOLD: threshold_reg <= pwdata[30:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_MODE:      prdata = {30'd0, mode_reg};
            REG_THRESHOLD: prdata = {1'b0, threshold_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // Global pipeline advance
    assign en       = m_tready || !m_tvalid;
    assign s_tready = en;

    pmt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .pixel     (s_tdata),
        .mode      (mode_reg),
        .threshold (threshold_reg),
        .out_valid (iv[0]),
        .out_item  (it[0])
    );

    // Iteration stages
    for (genvar g = 1; g <= LOG_ROUNDS; g++) begin : g_iter
        pmt_iter u_iter (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .idx       (6'(g)),
            .in_valid  (iv[g-1]),
            .in_item   (it[g-1]),
            .out_valid (iv[g]),
            .out_item  (it[g])
        );
    end

    pmt_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (iv[LOG_ROUNDS]),
        .in_item   (it[LOG_ROUNDS]),
        .out_valid (sc_valid),
        .out_item  (sc_item)
    );

    pmt_finish u_finish (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (sc_valid),
        .in_item      (sc_item),
        .out_valid    (m_tvalid),
        .value        (m_tdata),
        .domain_error (m_tuser)
    );

    // A flagged result always carries the saturated value
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == LOG_ZERO_VALUE))
        else $error("domain_error without saturated value");

    // A result appears only from a valid multiply stage entry
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(sc_valid))
        else $error("output valid without a pipeline entry");

    // The pipe holds while a result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> ($stable(sc_valid) && $stable(iv[0])))
        else $error("pipeline moved during output stall");

endmodule

>>> bench/pmt_checker.sv
// ----------------------------------------------------------------------------
// pmt_checker: output predictor and scoreboard for the magnitude transform
// Watches the pixel and result channels and the register writes, computes
// the expected Q32.32 value and error flag for every pixel transfer, and
// compares each result transfer against the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module pmt_checker
    import pmt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic        m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          pending_count,
    output int          result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] LOG10_OF_2 = 64'd1292913986;

    typedef struct packed {
        logic [63:0] value;
        logic        domain_error;
    } pmt_result_t;

    pmt_mode_t   cur_mode;
    logic [30:0] cur_threshold;
    pmt_result_t expected_results[$];

    // Floor of sqrt(a * 2^48), one digit per round
    function automatic logic [63:0] floor_sqrt48(input logic [63:0] a);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] trial;
        logic [63:0] pair;
        rem  = 0;
        root = 0;
        for (int i = 39; i >= 0; i--) begin
            pair = (2 * i >= 48) ? ((a >> (2 * i - 48)) & 64'd3) : 64'd0;
            rem  = (rem << 2) | pair;
            trial = (root << 2) | 64'd1;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = (root << 1) | 64'd1;
            end
            else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    // log10 of a Q16.16 value (a != 0), rounded to 2^-16, as Q32.32
    function automatic logic [63:0] log10_fixed(input logic [63:0] a);
        int          top;
        logic [63:0] m;
        logic [63:0] frac;
        logic [63:0] mag;
        logic [63:0] t;
        logic [63:0] v;
        logic        neg;
        top = 31;
        while (top > 0 && a[top] == 1'b0)
            top--;
        m    = (a << (31 - top)) & 64'hFFFF_FFFF;
        frac = 0;
        for (int i = 1; i <= 32; i++) begin
            m = (m * m) >> 31;
            if (m >= 64'h1_0000_0000) begin
                frac[32 - i] = 1'b1;
                m = m >> 1;
            end
        end
        neg = (top < 16);
        mag = neg ? ((64'(16 - top) << 32) - frac) : ((64'(top - 16) << 32) + frac);
        t = (((mag >> 32) * LOG10_OF_2) << 16)
            + (((mag & 64'hFFFF_FFFF) * LOG10_OF_2) >> 16);
        v = ((t + 64'h8000_0000) >> 32) << 16;
        return neg ? -v : v;
    endfunction

    function automatic pmt_result_t predict_transform(input logic [31:0] pixel);
        pmt_result_t r;
        logic [63:0] mag;
        logic [63:0] clamped;
        mag = pixel[31] ? {32'd0, 32'd0 - pixel} : {32'd0, pixel};
        if (pixel == 32'h8000_0000)
            mag = 64'h8000_0000;
        clamped = (mag < 64'(cur_threshold)) ? 64'(cur_threshold) : mag;
        r.domain_error = 1'b0;
        case (cur_mode)
            MODE_ABS:    r.value = mag << 16;
            MODE_SQUARE: r.value = mag * mag;
            MODE_SQRT:   r.value = floor_sqrt48(clamped);
            default:
            begin
                if (clamped == 0) begin
                    r.value        = LOG_ZERO_VALUE;
                    r.domain_error = 1'b1;
                end
                else begin
                    r.value = log10_fixed(clamped);
                end
            end
        endcase
        return r;
    endfunction

    assign pending_count = expected_results.size();

    always @(posedge clk or negedge rst_n) begin
        pmt_result_t got;
        pmt_result_t want;
        if (!rst_n) begin
            cur_mode      <= MODE_ABS;
            cur_threshold <= '0;
            fail_count    <= 0;
            result_count  <= 0;
            expected_results.delete();
        end
        else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_MODE)
                    cur_mode <= pmt_mode_t'(pwdata[1:0]);
                else
                    cur_threshold <= pwdata[30:0];
            end
            // pixel transfer
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_transform(s_tdata));
            // result transfer
            if (m_tvalid && m_tready) begin
                got.value        = m_tdata;
                got.domain_error = m_tuser;
                result_count <= result_count + 1;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result value=%h err=%b",
                             $time, m_tdata, m_tuser);
                    fail_count <= fail_count + 1;
                end
                else begin
                    want = expected_results.pop_front();
                    if (want.value !== got.value) begin
                        $display("%0t: value expected %h actual %h",
                                 $time, want.value, got.value);
                        fail_count <= fail_count + 1;
                    end
                    else if (want.domain_error !== got.domain_error) begin
                        $display("%0t: domain_error expected %b actual %b",
                                 $time, want.domain_error, got.domain_error);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for pixel_magnitude_transform_core
// Sweeps all modes and several thresholds with directed and random pixels,
// random idling on both channels, a long output stall and a full drain.
// ----------------------------------------------------------------------------
module tb;
    import pmt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_LATENCY = 35;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending_count;
    int          result_count;
    int          pixels_sent;
    bit          hold_off;

    pixel_magnitude_transform_core u_dut (.*);

    pmt_checker u_checker (.*);

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial begin
        #50ms;
        $display("tb failed");
        $finish;
    end

    // Result side: random stalls, plus a forced long hold-off
    initial begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_off)
                m_tready <= 1'b0;
            else if ($urandom_range(0, 3) != 0)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, 1) == 1);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic write_register(input logic idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_pixel(input logic [31:0] pixel, input int gap);
        s_tvalid <= 1'b1;
        s_tdata  <= pixel;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pixels_sent++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 5) @(posedge clk);
    endtask

    function automatic logic [31:0] random_pixel();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 255);
            1: return -$urandom_range(0, 255);
            2: return 32'h8000_0000 | $urandom_range(0, 3);
            3: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            4: return $urandom() >> $urandom_range(0, 31);
            default: return $urandom();
        endcase
    endfunction

    initial begin
        logic [31:0] directed[] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h0001_0000, 32'hFFFF_0000, 32'h000A_0000,
            32'h0000_8000, 32'h0064_0000, 32'hAAAA_AAAA, 32'h5555_5555};
        logic [31:0] thresholds[] = '{32'h0, 32'h7FFF_FFFF, 32'h0001_0000,
            32'h0000_0001, 32'h0};
        int per_phase;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        hold_off = 1'b0;
        pixels_sent = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every mode at zero threshold (log of zero included), with
        // upper bits of the register words set to check masking
        for (int md = 0; md < 4; md++) begin
            write_register(REG_MODE, 32'hFFFF_FFFC | md);
            write_register(REG_THRESHOLD, 32'h8000_0000);
            foreach (directed[k])
                if (md == 0 || k < 6)
                    send_pixel(directed[k], 0);
            drain_results();
        end

        // random phases over modes and thresholds
        per_phase = 1300 / 20;
        for (int ph = 0; ph < 20; ph++) begin
            write_register(REG_MODE, ph % 4);
            if (ph < 5 * 4 && ph % 4 == 0)
                write_register(REG_THRESHOLD,
                               (ph / 4 < 5) ? thresholds[ph / 4] : $urandom());
            if (ph == 9)
                write_register(REG_THRESHOLD, $urandom());
            if (ph == 6) begin
                // long output stall while pixels keep coming
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (120) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            for (int k = 0; k < per_phase; k++)
                send_pixel(random_pixel(), (ph % 5 == 2) ? 0 : pick_gap());
            drain_results();
        end

        $display("Covered %0d pixels and %0d results over all four modes,",
                 pixels_sent, result_count);
        $display("zero, unit and full-scale thresholds, stalls and drains.");
        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
